>>> src/bilinear_image_sampler_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bilinear image sampler
// Concurrent checks clocked on i_clk, off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_IMAGE_SAMPLER_ASSERT_SVH
`define BILINEAR_IMAGE_SAMPLER_ASSERT_SVH

// same-cycle implication
`define BIS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BIS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/bis_pkg.sv
// ----------------------------------------------------------------------------
// bis_pkg
// Shared widths, codes and helpers for the bilinear image sampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bis_pkg;

    localparam int COORD_W = 18;   // signed coordinate, fixed point
    localparam int PIX_W   = 24;   // signed Q8.16 pixel
    localparam int CFG_W   = 9;    // size register width

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_FRAC_BITS  = 8;

    localparam logic [CFG_W-1:0] RESET_SIZE = 9'd256;

    // request opcodes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // config register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // zero reads as one, anything above the store limit reads as the limit
    function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                    input int unsigned lim);
        logic [CFG_W-1:0] r;
        if (v == '0) begin
            r = CFG_W'(1);
        end else if (32'(v) > lim) begin
            r = CFG_W'(lim);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

>>> src/bis_axis.sv
// ----------------------------------------------------------------------------
// bis_axis
// Half-pixel offset, clamp to edge, neighbour indexes and fraction per axis.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bis_axis import bis_pkg::*; #(
    parameter int SIZE_MAX  = DEF_MAX_WIDTH,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic signed [COORD_W-1:0]           i_coord,
    input  logic        [CFG_W-1:0]             i_size,
    output logic        [$clog2(SIZE_MAX)-1:0]  o_i0,
    output logic        [$clog2(SIZE_MAX)-1:0]  o_i1,
    output logic        [FRAC_BITS-1:0]         o_frac
);

    localparam int IW = $clog2(SIZE_MAX);
    localparam int UW = (COORD_W + 1 > CFG_W + FRAC_BITS + 1) ?
                        COORD_W + 1 : CFG_W + FRAC_BITS + 1;
    localparam logic signed [UW-1:0] HALF = UW'(1) << (FRAC_BITS - 1);

    logic signed [UW-1:0] c_ext;
    logic signed [UW-1:0] u;
    logic signed [UW-1:0] hi;
    logic signed [UW-1:0] uc;
    logic        [UW-1:0] i0_full;
    logic        [UW-1:0] i0_inc;
    logic        [UW-1:0] last;

    always_comb begin
        c_ext   = {{(UW-COORD_W){i_coord[COORD_W-1]}}, i_coord};
        u       = c_ext - HALF;
        last    = UW'(i_size - CFG_W'(1));
        hi      = $signed(last << FRAC_BITS);
        if (u[UW-1]) begin
            uc = '0;
        end else if (u > hi) begin
            uc = hi;
        end else begin
            uc = u;
        end
        i0_full = $unsigned(uc) >> FRAC_BITS;
        i0_inc  = i0_full + UW'(1);
        o_i0    = i0_full[IW-1:0];
        o_i1    = (i0_full == last) ? i0_full[IW-1:0] : i0_inc[IW-1:0];
        o_frac  = uc[FRAC_BITS-1:0];
    end

endmodule

>>> src/bis_lerp_unit.sv
// ----------------------------------------------------------------------------
// bis_lerp_unit
// Shared lerp datapath: registered (b-a)*t, then a + floor((p + half) / 2^F).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bis_lerp_unit import bis_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_mul_en,
    input  logic signed [PIX_W-1:0] i_a,
    input  logic signed [PIX_W-1:0] i_b,
    input  logic [FRAC_BITS-1:0]    i_t,
    output logic signed [PIX_W-1:0] o_lerp
);

    localparam int PW = PIX_W + FRAC_BITS + 2;
    localparam logic signed [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

    logic signed [PIX_W:0]       diff;
    logic signed [FRAC_BITS:0]   t_s;
    logic signed [PW-1:0]        n_prod;
    logic signed [PW-1:0]        r_prod;
    logic signed [PW-1:0]        rounded;
    logic signed [PW-1:0]        sum;

    always_comb begin
        diff   = $signed({i_b[PIX_W-1], i_b}) - $signed({i_a[PIX_W-1], i_a});
        t_s    = $signed({1'b0, i_t});
        n_prod = PW'(diff) * PW'(t_s);
    end

    always_ff @(posedge i_clk) begin
        if (i_mul_en) begin
            r_prod <= n_prod;
        end
    end

    // result always lies between a and b, so the low bits are exact
    always_comb begin
        rounded = (r_prod + HALF) >>> FRAC_BITS;
        sum     = {{(PW-PIX_W){i_a[PIX_W-1]}}, i_a} + rounded;
        o_lerp  = sum[PIX_W-1:0];
    end

endmodule

>>> src/bis_pixel_mem.sv
// ----------------------------------------------------------------------------
// bis_pixel_mem
// Single-port pixel store with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bis_pixel_mem import bis_pkg::*; #(
    parameter int DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [PIX_W-1:0]         i_wdata,
    output logic [PIX_W-1:0]         o_rdata
);

    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/bilinear_image_sampler.sv
// ----------------------------------------------------------------------------
// bilinear_image_sampler: pixel store with clamp-to-edge bilinear sampling
// Write request: accepted with no result; a new request the next cycle.
// Sample request: four reads through the single-port store and three multiplier passes, then the
//   result register is loaded once the result channel has room; requests stall until then.
// Reset (sync, active low): sizes to 256, sequencer idle; pixels undefined until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bilinear_image_sampler import bis_pkg::*; #(
    parameter int MAX_WIDTH       = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT      = DEF_MAX_HEIGHT,
    parameter int COORD_FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // request channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_op,
    input  logic signed [COORD_W-1:0] i_coord_x,
    input  logic signed [COORD_W-1:0] i_coord_y,
    input  logic signed [PIX_W-1:0]   i_pixel_value,
    // result channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [PIX_W-1:0]   o_sample_value,
    // config write channel
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic                      i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_data
);

    `include "bilinear_image_sampler_assert.svh"

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    // Sequencer. A sample walks the four neighbour reads, overlapping the
    // first vertical lerp with the later reads, then finishes the second
    // vertical lerp and the horizontal one on the shared lerp unit.
    typedef enum logic [8:0] {
        S_IDLE  = 9'b0_0000_0001,
        S_RD0   = 9'b0_0000_0010,  // read (x0,y0)
        S_RD1   = 9'b0_0000_0100,  // read (x0,y1), keep p00
        S_RD2   = 9'b0_0000_1000,  // read (x1,y0), multiply for v0
        S_RD3   = 9'b0_0001_0000,  // read (x1,y1), v0 done, keep p10
        S_MULV1 = 9'b0_0010_0000,  // multiply for v1
        S_SUMV1 = 9'b0_0100_0000,  // v1 done
        S_MULX  = 9'b0_1000_0000,  // multiply horizontal
        S_DONE  = 9'b1_0000_0000   // final sum into result register
    } t_state;

    t_state r_state;
    t_state n_state;

    // size registers
    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;

    // latched axis results for the sample in flight
    logic [XW-1:0]              r_x0, r_x1;
    logic [YW-1:0]              r_y0, r_y1;
    logic [COORD_FRAC_BITS-1:0] r_fx, r_fy;

    // lerp operand holding registers
    logic signed [PIX_W-1:0] r_base;
    logic signed [PIX_W-1:0] r_v0;
    logic signed [PIX_W-1:0] r_v1;

    // result register
    logic                    r_out_valid;
    logic signed [PIX_W-1:0] r_out_data;

    logic in_acc;
    logic out_room;
    logic out_take;

    // axis decode straight from the request ports
    logic [XW-1:0]              ax_x0, ax_x1;
    logic [YW-1:0]              ax_y0, ax_y1;
    logic [COORD_FRAC_BITS-1:0] ax_fx, ax_fy;

    bis_axis #(
        .SIZE_MAX  (MAX_WIDTH),
        .FRAC_BITS (COORD_FRAC_BITS)
    ) u_axis_x (
        .i_coord (i_coord_x),
        .i_size  (r_width),
        .o_i0    (ax_x0),
        .o_i1    (ax_x1),
        .o_frac  (ax_fx)
    );

    bis_axis #(
        .SIZE_MAX  (MAX_HEIGHT),
        .FRAC_BITS (COORD_FRAC_BITS)
    ) u_axis_y (
        .i_coord (i_coord_y),
        .i_size  (r_height),
        .o_i0    (ax_y0),
        .o_i1    (ax_y1),
        .o_frac  (ax_fy)
    );

    // Write decode: integer part is the floor (arithmetic shift); writes
    // outside the image in use are dropped.
    logic signed [COORD_W-1:0] wr_x;
    logic signed [COORD_W-1:0] wr_y;
    logic                      wr_ok;

    always_comb begin
        wr_x  = i_coord_x >>> COORD_FRAC_BITS;
        wr_y  = i_coord_y >>> COORD_FRAC_BITS;
        wr_ok = !wr_x[COORD_W-1] && !wr_y[COORD_W-1] &&
                ($unsigned(wr_x) < COORD_W'(r_width)) &&
                ($unsigned(wr_y) < COORD_W'(r_height));
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_take   = r_out_valid && !i_out_stall;
    assign out_room   = !r_out_valid || !i_out_stall;

    // Store port: write in the accept cycle, reads in RD0..RD3.
    logic [XW-1:0]    mem_x;
    logic [YW-1:0]    mem_y;
    logic [AW-1:0]    mem_addr;
    logic             mem_we;
    logic             mem_re;
    logic [PIX_W-1:0] mem_rdata;

    always_comb begin
        unique case (r_state)
            S_RD0: begin
                mem_x = r_x0;
                mem_y = r_y0;
            end
            S_RD1: begin
                mem_x = r_x0;
                mem_y = r_y1;
            end
            S_RD2: begin
                mem_x = r_x1;
                mem_y = r_y0;
            end
            S_RD3: begin
                mem_x = r_x1;
                mem_y = r_y1;
            end
            default: begin
                mem_x = wr_x[XW-1:0];
                mem_y = wr_y[YW-1:0];
            end
        endcase
        mem_addr = AW'(mem_y) * AW'(MAX_WIDTH) + AW'(mem_x);
        mem_we   = in_acc && (i_op == OP_WRITE) && wr_ok;
        mem_re   = (r_state == S_RD0) || (r_state == S_RD1) ||
                   (r_state == S_RD2) || (r_state == S_RD3);
    end

    bis_pixel_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (i_pixel_value),
        .o_rdata (mem_rdata)
    );

    // Shared lerp unit operand select. Base stays put between the multiply
    // and the finishing add of each lerp.
    logic                       lu_mul_en;
    logic signed [PIX_W-1:0]    lu_a;
    logic signed [PIX_W-1:0]    lu_b;
    logic [COORD_FRAC_BITS-1:0] lu_t;
    logic signed [PIX_W-1:0]    lu_out;

    always_comb begin
        lu_mul_en = (r_state == S_RD2) || (r_state == S_MULV1) || (r_state == S_MULX);
        if ((r_state == S_MULX) || (r_state == S_DONE)) begin
            lu_a = r_v0;
            lu_b = r_v1;
            lu_t = r_fx;
        end else begin
            lu_a = r_base;
            lu_b = $signed(mem_rdata);
            lu_t = r_fy;
        end
    end

    bis_lerp_unit #(
        .FRAC_BITS (COORD_FRAC_BITS)
    ) u_lerp (
        .i_clk    (i_clk),
        .i_mul_en (lu_mul_en),
        .i_a      (lu_a),
        .i_b      (lu_b),
        .i_t      (lu_t),
        .o_lerp   (lu_out)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_op == OP_SAMPLE)) begin
                    n_state = S_RD0;
                end
            end
            S_RD0:   n_state = S_RD1;
            S_RD1:   n_state = S_RD2;
            S_RD2:   n_state = S_RD3;
            S_RD3:   n_state = S_MULV1;
            S_MULV1: n_state = S_SUMV1;
            S_SUMV1: n_state = S_MULX;
            S_MULX:  n_state = S_DONE;
            S_DONE: begin
                if (out_room) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_width     <= clamp_size(RESET_SIZE, MAX_WIDTH);
            r_height    <= clamp_size(RESET_SIZE, MAX_HEIGHT);
        end else begin
            r_state <= n_state;
            if ((r_state == S_DONE) && out_room) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_WIDTH:  r_width  <= clamp_size(i_cfg_data, MAX_WIDTH);
                    REG_HEIGHT: r_height <= clamp_size(i_cfg_data, MAX_HEIGHT);
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_op == OP_SAMPLE)) begin
            r_x0 <= ax_x0;
            r_x1 <= ax_x1;
            r_fx <= ax_fx;
            r_y0 <= ax_y0;
            r_y1 <= ax_y1;
            r_fy <= ax_fy;
        end
        if (r_state == S_RD1) begin
            r_base <= $signed(mem_rdata);     // p(x0,y0)
        end
        if (r_state == S_RD3) begin
            r_v0   <= lu_out;
            r_base <= $signed(mem_rdata);     // p(x1,y0)
        end
        if (r_state == S_SUMV1) begin
            r_v1 <= lu_out;
        end
        if ((r_state == S_DONE) && out_room) begin
            r_out_data <= lu_out;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sample_value = r_out_data;
    assign o_cfg_ready    = 1'b1;

    // checks
    `BIS_ASSERT_NEXT(a_sample_starts, in_acc && (i_op == OP_SAMPLE), r_state == S_RD0, "sample request did not start the read sequence")
    `BIS_ASSERT_NEXT(a_write_single, in_acc && (i_op == OP_WRITE), r_state == S_IDLE, "write request left the sequencer busy")
    `BIS_ASSERT_SAME(a_result_source, o_out_valid && !$past(o_out_valid), $past(r_state == S_DONE), "result appeared without a finished sample")
    `BIS_ASSERT_SAME(a_size_nonzero, 1'b1, (r_width != '0) && (r_height != '0), "image size register holds zero")

endmodule
